// File: hdl/tpbba_pkg.sv
// Package of the two-priority byte budget admitter: shared types, codes
// and default sizes. Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package tpbba_pkg;

   localparam int HIGH_DEPTH_DEF = 16;
   localparam int LOW_DEPTH_DEF  = 16;
   localparam int BYTES_W        = 48;
   localparam int TICKET_W       = 8;

   typedef enum logic [2:0] {
      OP_ACQUIRE = 3'd0,
      OP_TRY     = 3'd1,
      OP_RELEASE = 3'd2,
      OP_CANCEL  = 3'd3,
      OP_RECHECK = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_ADMITTED    = 4'd0,
      ST_QUEUED      = 4'd1,
      ST_QUEUE_FULL  = 4'd2,
      ST_TRY_REFUSED = 4'd3,
      ST_RELEASED    = 4'd4,
      ST_OVER_REL    = 4'd5,
      ST_CANCELLED   = 4'd6,
      ST_NOT_PENDING = 4'd7,
      ST_RECHECKED   = 4'd8,
      ST_ADMIT_QUEUE = 4'd9
   } status_type;

   // Where the bytes and ticket of a produced result come from.
   typedef enum logic [1:0] {
      SRC_REQ  = 2'd0,
      SRC_HEAD = 2'd1,
      SRC_ZERO = 2'd2
   } src_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_FIN,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DRAIN_START,
      S_DRAIN_RD,
      S_DRAIN_CHK
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       sel_set;
      logic       sel_low;
      logic       idx_clr;
      logic       idx_inc;
      logic       mem_rd;
      logic       rd_next;
      logic       mem_wr;
      logic       enq;
      logic       cnt_dec;
      logic       infl_add;
      logic       infl_sub;
      logic       produce;
      logic       finish;
      status_type status;
      src_type    src;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       req_clear;
      logic       fits_req;
      logic       fits_head;
      logic       q_full;
      logic       over_rel;
      logic       idx_end;
      logic       shift_end;
      logic       cnt_zero;
      logic       tk_match;
      logic       sel_low;
      logic       pend_valid;
      logic       out_free;
   } sts_type;

endpackage

// File: hdl/tpbba_ctrl.sv
// Controller of the byte budget admitter: one state machine that sequences
// admission, search, queue compaction and draining. Depends on tpbba_pkg.
`timescale 1ns / 1ps
module tpbba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tpbba_pkg::sts_type sts,
   output tpbba_pkg::cmd_type cmd
);

   tpbba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpbba_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         tpbba_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = tpbba_pkg::S_EXEC;
            end
         end
         tpbba_pkg::S_EXEC: begin
            unique case (sts.op)
               tpbba_pkg::OP_ACQUIRE, tpbba_pkg::OP_TRY: begin
                  cmd.produce = 1'b1;
                  cmd.src     = tpbba_pkg::SRC_REQ;
                  state_in    = tpbba_pkg::S_FIN;
                  if (sts.req_clear && sts.fits_req) begin
                     cmd.infl_add = 1'b1;
                     cmd.status   = tpbba_pkg::ST_ADMITTED;
                  end else if (sts.op == tpbba_pkg::OP_TRY) begin
                     cmd.status = tpbba_pkg::ST_TRY_REFUSED;
                  end else if (sts.q_full) begin
                     cmd.status = tpbba_pkg::ST_QUEUE_FULL;
                  end else begin
                     cmd.enq    = 1'b1;
                     cmd.status = tpbba_pkg::ST_QUEUED;
                  end
               end
               tpbba_pkg::OP_RELEASE: begin
                  cmd.produce = 1'b1;
                  cmd.src     = tpbba_pkg::SRC_REQ;
                  if (sts.over_rel) begin
                     cmd.status = tpbba_pkg::ST_OVER_REL;
                     state_in   = tpbba_pkg::S_FIN;
                  end else begin
                     cmd.infl_sub = 1'b1;
                     cmd.status   = tpbba_pkg::ST_RELEASED;
                     state_in     = tpbba_pkg::S_DRAIN_START;
                  end
               end
               tpbba_pkg::OP_CANCEL: begin
                  cmd.sel_set = 1'b1;
                  cmd.sel_low = 1'b0;
                  cmd.idx_clr = 1'b1;
                  state_in    = tpbba_pkg::S_SRCH_RD;
               end
               tpbba_pkg::OP_RECHECK: begin
                  cmd.produce = 1'b1;
                  cmd.src     = tpbba_pkg::SRC_ZERO;
                  cmd.status  = tpbba_pkg::ST_RECHECKED;
                  state_in    = tpbba_pkg::S_DRAIN_START;
               end
               default: begin
                  state_in = tpbba_pkg::S_IDLE;
               end
            endcase
         end
         tpbba_pkg::S_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = tpbba_pkg::S_IDLE;
            end
         end
         tpbba_pkg::S_SRCH_RD: begin
            if (sts.idx_end) begin
               if (!sts.sel_low) begin
                  cmd.sel_set = 1'b1;
                  cmd.sel_low = 1'b1;
                  cmd.idx_clr = 1'b1;
               end else begin
                  cmd.produce = 1'b1;
                  cmd.src     = tpbba_pkg::SRC_ZERO;
                  cmd.status  = tpbba_pkg::ST_NOT_PENDING;
                  state_in    = tpbba_pkg::S_FIN;
               end
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = tpbba_pkg::S_SRCH_CMP;
            end
         end
         tpbba_pkg::S_SRCH_CMP: begin
            if (sts.tk_match) begin
               cmd.produce = 1'b1;
               cmd.src     = tpbba_pkg::SRC_HEAD;
               cmd.status  = tpbba_pkg::ST_CANCELLED;
               state_in    = tpbba_pkg::S_SHIFT_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = tpbba_pkg::S_SRCH_RD;
            end
         end
         tpbba_pkg::S_SHIFT_RD: begin
            if (sts.shift_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = tpbba_pkg::S_DRAIN_START;
            end else begin
               cmd.mem_rd  = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = tpbba_pkg::S_SHIFT_WR;
            end
         end
         tpbba_pkg::S_SHIFT_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = tpbba_pkg::S_SHIFT_RD;
         end
         tpbba_pkg::S_DRAIN_START: begin
            cmd.sel_set = 1'b1;
            cmd.sel_low = 1'b0;
            cmd.idx_clr = 1'b1;
            state_in    = tpbba_pkg::S_DRAIN_RD;
         end
         tpbba_pkg::S_DRAIN_RD: begin
            if (sts.cnt_zero) begin
               if (!sts.sel_low) begin
                  cmd.sel_set = 1'b1;
                  cmd.sel_low = 1'b1;
               end else begin
                  state_in = tpbba_pkg::S_FIN;
               end
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = tpbba_pkg::S_DRAIN_CHK;
            end
         end
         tpbba_pkg::S_DRAIN_CHK: begin
            if (!sts.fits_head) begin
               state_in = tpbba_pkg::S_FIN;
            end else if (sts.out_free) begin
               cmd.infl_add = 1'b1;
               cmd.produce  = 1'b1;
               cmd.src      = tpbba_pkg::SRC_HEAD;
               cmd.status   = tpbba_pkg::ST_ADMIT_QUEUE;
               state_in     = tpbba_pkg::S_SHIFT_RD;
            end
         end
         default: begin
            state_in = tpbba_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/tpbba_dp.sv
// Datapath of the byte budget admitter: budget registers, the two queue
// memories, search index, pending result and output register. Uses tpbba_pkg.
`timescale 1ns / 1ps
module tpbba_dp #(
   parameter int HIGH_DEPTH = tpbba_pkg::HIGH_DEPTH_DEF,
   parameter int LOW_DEPTH  = tpbba_pkg::LOW_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         req_tdata,
   input  logic                req_tuser,
   input  logic                csr_valid,
   input  logic [47:0]         csr_data,
   output logic [111:0]        rsp_tdata,
   output logic                rsp_tvalid,
   output logic                rsp_tlast,
   input  logic                rsp_tready,
   input  tpbba_pkg::cmd_type  cmd,
   output tpbba_pkg::sts_type  sts
);

   localparam int HIW  = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
   localparam int LIW  = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
   localparam int HCW  = $clog2(HIGH_DEPTH + 1);
   localparam int LCW  = $clog2(LOW_DEPTH + 1);
   localparam int MAXD = (HIGH_DEPTH > LOW_DEPTH) ? HIGH_DEPTH : LOW_DEPTH;
   localparam int IDXW = $clog2(MAXD + 1);
   localparam int EW   = tpbba_pkg::TICKET_W + tpbba_pkg::BYTES_W;

   function automatic logic fits_f(input logic [47:0] b, input logic [47:0] cap,
                                   input logic [47:0] infl);
      logic r;
      if (cap == '0) begin
         r = 1'b1;
      end else if (b > cap) begin
         r = (infl == '0);
      end else begin
         r = (infl <= cap) && (b <= cap - infl);
      end
      return r;
   endfunction

   logic [EW-1:0] high_mem [HIGH_DEPTH];
   logic [EW-1:0] low_mem  [LOW_DEPTH];

   logic [47:0]     cap_ff, infl_ff, infl_in;
   logic [2:0]      op_ff;
   logic [7:0]      tk_ff;
   logic [47:0]     b_ff;
   logic            hi_ff;
   logic            sel_ff;
   logic [IDXW-1:0] idx_ff, idx_p1;
   logic [HCW-1:0]  hcnt_ff;
   logic [LCW-1:0]  lcnt_ff;
   logic [EW-1:0]   rd_ff;
   logic            pend_valid_ff;
   logic [107:0]    pend_ff, pend_in;
   logic            rsp_valid_ff, rsp_last_ff;
   logic [107:0]    rsp_data_ff;
   logic [IDXW-1:0] cnt_sel;
   logic [47:0]     opnd, res_bytes;
   logic [7:0]      res_tk;
   logic [48:0]     sum;
   logic            out_free;

   assign idx_p1   = idx_ff + 1'b1;
   assign cnt_sel  = sel_ff ? IDXW'(lcnt_ff) : IDXW'(hcnt_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // In-flight update: saturating add, plain subtract (checked beforehand).
   assign opnd = (cmd.src == tpbba_pkg::SRC_HEAD) ? rd_ff[47:0] : b_ff;
   assign sum  = {1'b0, infl_ff} + {1'b0, opnd};
   always_comb begin
      infl_in = infl_ff;
      if (cmd.infl_add) begin
         infl_in = sum[48] ? '1 : sum[47:0];
      end else if (cmd.infl_sub) begin
         infl_in = infl_ff - b_ff;
      end
   end

   always_comb begin
      unique case (cmd.src)
         tpbba_pkg::SRC_HEAD: begin
            res_bytes = rd_ff[47:0];
            res_tk    = rd_ff[55:48];
         end
         tpbba_pkg::SRC_ZERO: begin
            res_bytes = '0;
            res_tk    = tk_ff;
         end
         default: begin
            res_bytes = b_ff;
            res_tk    = tk_ff;
         end
      endcase
      pend_in = {infl_in, res_bytes, res_tk, cmd.status};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= '0;
         infl_ff       <= '0;
         hcnt_ff       <= '0;
         lcnt_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         infl_ff <= infl_in;
         if (cmd.enq) begin
            if (hi_ff) begin
               hcnt_ff <= hcnt_ff + 1'b1;
            end else begin
               lcnt_ff <= lcnt_ff + 1'b1;
            end
         end else if (cmd.cnt_dec) begin
            if (sel_ff) begin
               lcnt_ff <= lcnt_ff - 1'b1;
            end else begin
               hcnt_ff <= hcnt_ff - 1'b1;
            end
         end
         if (cmd.produce) begin
            pend_valid_ff <= 1'b1;
            if (pend_valid_ff) begin
               rsp_valid_ff <= 1'b1;
            end else if (rsp_tready) begin
               rsp_valid_ff <= 1'b0;
            end
         end else if (cmd.finish) begin
            pend_valid_ff <= 1'b0;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_tdata[2:0];
         tk_ff <= req_tdata[10:3];
         b_ff  <= req_tdata[58:11];
         hi_ff <= req_tuser;
      end
      if (cmd.sel_set) begin
         sel_ff <= cmd.sel_low;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_p1;
      end
      if (cmd.mem_rd) begin
         if (sel_ff) begin
            rd_ff <= low_mem[cmd.rd_next ? idx_p1[LIW-1:0] : idx_ff[LIW-1:0]];
         end else begin
            rd_ff <= high_mem[cmd.rd_next ? idx_p1[HIW-1:0] : idx_ff[HIW-1:0]];
         end
      end
      if (cmd.produce) begin
         pend_ff <= pend_in;
         if (pend_valid_ff) begin
            rsp_data_ff <= pend_ff;
            rsp_last_ff <= 1'b0;
         end
      end else if (cmd.finish) begin
         rsp_data_ff <= pend_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enq && hi_ff) begin
         high_mem[hcnt_ff[HIW-1:0]] <= {tk_ff, b_ff};
      end else if (cmd.mem_wr && !sel_ff) begin
         high_mem[idx_ff[HIW-1:0]] <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enq && !hi_ff) begin
         low_mem[lcnt_ff[LIW-1:0]] <= {tk_ff, b_ff};
      end else if (cmd.mem_wr && sel_ff) begin
         low_mem[idx_ff[LIW-1:0]] <= rd_ff;
      end
   end

   always_comb begin
      sts            = '0;
      sts.op         = op_ff;
      sts.req_clear  = hi_ff ? (hcnt_ff == '0) : ((hcnt_ff == '0) && (lcnt_ff == '0));
      sts.fits_req   = fits_f(b_ff, cap_ff, infl_ff);
      sts.fits_head  = fits_f(rd_ff[47:0], cap_ff, infl_ff);
      sts.q_full     = hi_ff ? (hcnt_ff == HCW'(HIGH_DEPTH)) : (lcnt_ff == LCW'(LOW_DEPTH));
      sts.over_rel   = (b_ff > infl_ff);
      sts.idx_end    = (idx_ff >= cnt_sel);
      sts.shift_end  = (idx_p1 >= cnt_sel);
      sts.cnt_zero   = (cnt_sel == '0);
      sts.tk_match   = (rd_ff[55:48] == tk_ff);
      sts.sel_low    = sel_ff;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   assign rsp_tdata  = {4'b0000, rsp_data_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hdl/two_priority_byte_budget_admitter_top.sv
// Top level of the two-priority byte budget admitter: joins the controller
// and the datapath. Depends on tpbba_pkg, tpbba_ctrl and tpbba_dp.
`timescale 1ns / 1ps
// Usage
// Requests arrive as words on the req_ channel (acquire, try acquire,
// release, cancel, recheck) and are admitted against the byte capacity held
// in the csr_ register; a capacity of zero admits everything. Each request
// gives one or more result words on the rsp_ channel, the last one marked by
// rsp_tlast; admissions from the high and low waiting queues follow the
// word that reports the request itself.
// One request is handled at a time. An acquire, try acquire or over-release
// offers its word on the rsp_ channel once it has passed the request
// registers, the pending result and the output register. A cancel checks
// the waiting entries one at a time; every removal from a queue, by cancel
// or by admission from its head, compacts it by reading and writing back
// each entry behind the removed one through the single read port of its
// queue memory. A new request is taken once the last word of the previous
// one is in the output register, so the block accepts while that word waits.
// Reset clears the in-flight total, the capacity and both queues; the
// queue memories need no clearing pass. When the receiver stalls, the
// output register holds its word and the controller waits before it
// produces the next one; no word is lost.
module two_priority_byte_budget_admitter_top #(
   parameter int HIGH_DEPTH = tpbba_pkg::HIGH_DEPTH_DEF,
   parameter int LOW_DEPTH  = tpbba_pkg::LOW_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: op [2:0], ticket [10:3], bytes [58:11], zero padding above
   input  logic [63:0]  req_tdata,
   // req_tuser: high_priority
   input  logic         req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // csr_data: byte budget, zero for unlimited
   input  logic [47:0]  csr_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   // rsp_tdata: status [3:0], out_ticket [11:4], out_bytes [59:12],
   // inflight_now [107:60], zero padding above
   output logic [111:0] rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   tpbba_pkg::cmd_type cmd;
   tpbba_pkg::sts_type sts;

   // The capacity register can always take a write.
   assign csr_ready = 1'b1;

   tpbba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tpbba_dp #(
      .HIGH_DEPTH (HIGH_DEPTH),
      .LOW_DEPTH  (LOW_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The request channel is closed in the cycle after a request is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous one was still in work");

   // Closing a request only when the output register can take the word.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("final word pushed into an occupied output register");

   // A new result may displace the pending one only into a free output.
   a_produce_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.produce && sts.pend_valid) |-> sts.out_free)
      else $error("pending word overwritten while the output stalls");

   // The request channel opens only with no result left pending.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.pend_valid)
      else $error("ready for a request with a result still pending");

endmodule

// File: verif/two_priority_byte_budget_admitter_top_tb.sv
// Self-checking testbench of the two-priority byte budget admitter top level.
// Depends on tpbba_pkg and two_priority_byte_budget_admitter_top; a built-in
// admission model predicts every result word, which is checked in order.
`timescale 1ns / 1ps
module two_priority_byte_budget_admitter_top_tb;

   localparam logic [47:0] BYTES_MAX   = 48'hFFFF_FFFF_FFFF;
   localparam int          QDEPTH      = tpbba_pkg::HIGH_DEPTH_DEF;
   localparam int          LQDEPTH     = tpbba_pkg::LOW_DEPTH_DEF;
   // Codes outside the defined operations; the block must ignore them.
   localparam logic [2:0]  OP_UNUSED_A = 3'd5;
   localparam logic [2:0]  OP_UNUSED_B = 3'd7;
   // Settling time before a capacity write and at the end. A request gives
   // its last word only once any compaction of a queue is done, so none is
   // still under way when the last expected word has come.
   localparam int          SETTLE      = 80;
   // The slowest correct run: 33 words per word in, each admission compacting
   // its queue and each word waiting out a receiver stall; the limit is taken
   // with margin over that worst case.
   localparam int          CYCLE_LIMIT = 2_000_000;
   localparam int          CHUNKS      = 16;
   localparam int          CHUNK_ITEMS = 25;

   typedef struct {
      tpbba_pkg::status_type st;
      logic [7:0]  tk;
      logic [47:0] nbytes;
      logic [47:0] infl;
      logic        last;
   } outcome_type;

   typedef struct {
      logic [7:0]  tk;
      logic [47:0] nbytes;
   } waiter_type;

   typedef struct {
      bit          is_csr;
      logic [2:0]  op;
      logic [7:0]  tk;
      logic [47:0] nbytes;
      logic        hi;
      bit          typed;
      tpbba_pkg::status_type st;
      logic [47:0] ebytes;
      logic [47:0] einfl;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [63:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  csr_data = '0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [111:0] rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;

   // Model state: the capacity, the in-flight total and both waiting queues.
   logic [47:0]  model_capacity;
   logic [47:0]  model_inflight;
   waiter_type   high_wait[$];
   waiter_type   low_wait[$];
   outcome_type  pending_words[$];

   int           errors = 0;
   int           cycles = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   two_priority_byte_budget_admitter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // The watchdog. Reaching the limit means the block has hung somewhere.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The receiver. Back-pressure is drawn afresh on every cycle, so stalls
   // land on every phase of the block's work.
   always @(posedge clock) begin
      rsp_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
   end

   // A request fits when capacity is unlimited, when an oversized request
   // meets an empty pipe, or when it fits in the room that is left.
   function automatic bit fits(input logic [47:0] b);
      if (model_capacity == 0) return 1'b1;
      if (b > model_capacity) return model_inflight == 0;
      return model_inflight <= model_capacity && b <= model_capacity - model_inflight;
   endfunction

   // Adds to the in-flight total, saturating at the top of the 48-bit range.
   function automatic void add_inflight(input logic [47:0] b);
      logic [48:0] sum;
      sum = {1'b0, model_inflight} + {1'b0, b};
      model_inflight = sum[48] ? BYTES_MAX : sum[47:0];
   endfunction

   function automatic outcome_type word_of(input tpbba_pkg::status_type st,
                                           input logic [7:0] tk, input logic [47:0] b);
      outcome_type w;
      w.st = st;
      w.tk = tk;
      w.nbytes = b;
      w.infl = model_inflight;
      w.last = 1'b0;
      return w;
   endfunction

   // Admits queue heads while they fit: the high queue first, the low queue
   // only once the high queue has emptied.
   function automatic void admit_waiters(ref outcome_type words[$]);
      while (high_wait.size() > 0 && fits(high_wait[0].nbytes)) begin
         add_inflight(high_wait[0].nbytes);
         words.push_back(word_of(tpbba_pkg::ST_ADMIT_QUEUE, high_wait[0].tk,
                                 high_wait[0].nbytes));
         void'(high_wait.pop_front());
      end
      if (high_wait.size() == 0) begin
         while (low_wait.size() > 0 && fits(low_wait[0].nbytes)) begin
            add_inflight(low_wait[0].nbytes);
            words.push_back(word_of(tpbba_pkg::ST_ADMIT_QUEUE, low_wait[0].tk,
                                    low_wait[0].nbytes));
            void'(low_wait.pop_front());
         end
      end
   endfunction

   // Removes the oldest waiter with the ticket; returns 1 and its bytes if found.
   function automatic bit withdraw(ref waiter_type q[$], input logic [7:0] tk,
                                   output logic [47:0] b);
      foreach (q[i]) begin
         if (q[i].tk == tk) begin
            b = q[i].nbytes;
            q.delete(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Works out the words one accepted request gives and updates the model.
   function automatic void predict_admission(input logic [2:0] op, input logic [7:0] tk,
                                             input logic [47:0] b, input logic hi,
                                             ref outcome_type words[$]);
      bit          clear;
      logic [47:0] found;
      waiter_type  w;
      w.tk = tk;
      w.nbytes = b;
      case (op)
         tpbba_pkg::OP_ACQUIRE, tpbba_pkg::OP_TRY: begin
            clear = hi ? (high_wait.size() == 0)
                       : (high_wait.size() == 0 && low_wait.size() == 0);
            if (clear && fits(b)) begin
               add_inflight(b);
               words.push_back(word_of(tpbba_pkg::ST_ADMITTED, tk, b));
            end else if (op == tpbba_pkg::OP_TRY) begin
               words.push_back(word_of(tpbba_pkg::ST_TRY_REFUSED, tk, b));
            end else if (hi) begin
               if (high_wait.size() < QDEPTH) begin
                  high_wait.push_back(w);
                  words.push_back(word_of(tpbba_pkg::ST_QUEUED, tk, b));
               end else begin
                  words.push_back(word_of(tpbba_pkg::ST_QUEUE_FULL, tk, b));
               end
            end else begin
               if (low_wait.size() < LQDEPTH) begin
                  low_wait.push_back(w);
                  words.push_back(word_of(tpbba_pkg::ST_QUEUED, tk, b));
               end else begin
                  words.push_back(word_of(tpbba_pkg::ST_QUEUE_FULL, tk, b));
               end
            end
         end
         tpbba_pkg::OP_RELEASE: begin
            if (b > model_inflight) begin
               words.push_back(word_of(tpbba_pkg::ST_OVER_REL, tk, b));
            end else begin
               model_inflight = model_inflight - b;
               words.push_back(word_of(tpbba_pkg::ST_RELEASED, tk, b));
               admit_waiters(words);
            end
         end
         tpbba_pkg::OP_CANCEL: begin
            if (withdraw(high_wait, tk, found) || withdraw(low_wait, tk, found)) begin
               words.push_back(word_of(tpbba_pkg::ST_CANCELLED, tk, found));
               admit_waiters(words);
            end else begin
               words.push_back(word_of(tpbba_pkg::ST_NOT_PENDING, tk, '0));
            end
         end
         tpbba_pkg::OP_RECHECK: begin
            words.push_back(word_of(tpbba_pkg::ST_RECHECKED, tk, '0));
            admit_waiters(words);
         end
         default: ;
      endcase
      if (words.size() > 0) words[words.size() - 1].last = 1'b1;
   endfunction

   // Capacity write, only with the block idle: the request channel is closed,
   // every expected word has come and the settling pause has passed.
   task automatic write_capacity(input logic [47:0] cap);
      req_tvalid <= 1'b0;
      while (pending_words.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      model_capacity = cap;
   endtask

   // Offers one request word and predicts its words once it is accepted.
   // The valid is only lowered when a sender gap is drawn.
   task automatic send_request(input logic [2:0] op, input logic [7:0] tk,
                               input logic [47:0] b, input logic hi,
                               input bit typed, input outcome_type typed_word);
      outcome_type words[$];
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, b, tk, op};
      req_tuser <= hi;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predict_admission(op, tk, b, hi, words);
      if (typed) begin
         words.delete();
         words.push_back(typed_word);
      end
      foreach (words[i]) pending_words.push_back(words[i]);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic stim_row_type row(input bit is_csr, input logic [2:0] op,
                                        input logic [7:0] tk, input logic [47:0] b,
                                        input logic hi, input bit typed = 1'b0,
                                        input tpbba_pkg::status_type st =
                                           tpbba_pkg::ST_ADMITTED,
                                        input logic [47:0] eb = '0,
                                        input logic [47:0] ei = '0);
      stim_row_type r;
      r.is_csr = is_csr;
      r.op = op;
      r.tk = tk;
      r.nbytes = b;
      r.hi = hi;
      r.typed = typed;
      r.st = st;
      r.ebytes = eb;
      r.einfl = ei;
      return r;
   endfunction

   // Bytes for a request: mostly around the capacity, sometimes anything.
   function automatic logic [47:0] pick_bytes(input bit for_release);
      int unsigned sel;
      logic [47:0] span;
      sel = $urandom_range(99);
      if (sel < 8) return BYTES_MAX;
      if (sel < 20) return 48'({$urandom, $urandom});
      if (for_release && model_inflight <= 48'hFFFF_FFFF && sel < 85)
         return 48'($urandom_range(0, model_inflight[31:0]));
      span = (model_capacity == 0 || model_capacity > 300) ? 48'd300 : 2 * model_capacity;
      return 48'($urandom_range(0, span[31:0]));
   endfunction

   // The checker. Every handshaked word is compared with the oldest one
   // expected; an unexpected word is a failure of its own.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, actual %h last %b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata[3:0] != want.st) begin
               $display("%0t: status expected %0d actual %0d", $time, want.st, rsp_tdata[3:0]);
               errors++;
            end
            if (rsp_tdata[11:4] != want.tk) begin
               $display("%0t: ticket expected %0d actual %0d", $time, want.tk, rsp_tdata[11:4]);
               errors++;
            end
            if (rsp_tdata[59:12] != want.nbytes) begin
               $display("%0t: bytes expected %h actual %h", $time, want.nbytes,
                        rsp_tdata[59:12]);
               errors++;
            end
            if (rsp_tdata[107:60] != want.infl) begin
               $display("%0t: in-flight expected %h actual %h", $time, want.infl,
                        rsp_tdata[107:60]);
               errors++;
            end
            if (rsp_tlast != want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type dir_tab[];
      outcome_type  tw;
      logic [47:0]  cap;
      logic [2:0]   op;
      logic [7:0]   tk;
      int unsigned  sel;
      int           waited;

      model_capacity = '0;
      model_inflight = '0;

      // Directed walk. Typed expectations stand only where the answer is
      // plain: from reset, at the extremes and for the refusal codes.
      dir_tab = '{
         row(0, tpbba_pkg::OP_ACQUIRE, 8'd1, 48'd0, 1'b0, 1, tpbba_pkg::ST_ADMITTED,
             48'd0, 48'd0),
         row(0, tpbba_pkg::OP_ACQUIRE, 8'd2, BYTES_MAX, 1'b1, 1, tpbba_pkg::ST_ADMITTED,
             BYTES_MAX, BYTES_MAX),
         // The in-flight total saturates here.
         row(0, tpbba_pkg::OP_TRY, 8'd3, 48'd5, 1'b0),
         row(0, tpbba_pkg::OP_RELEASE, 8'd2, BYTES_MAX, 1'b0, 1, tpbba_pkg::ST_RELEASED,
             BYTES_MAX, 48'd0),
         row(0, tpbba_pkg::OP_RELEASE, 8'd4, 48'd1, 1'b0, 1, tpbba_pkg::ST_OVER_REL,
             48'd1, 48'd0),
         row(0, tpbba_pkg::OP_CANCEL, 8'd9, 48'd0, 1'b0, 1, tpbba_pkg::ST_NOT_PENDING,
             48'd0, 48'd0),
         row(0, tpbba_pkg::OP_RECHECK, 8'd200, 48'd0, 1'b0, 1, tpbba_pkg::ST_RECHECKED,
             48'd0, 48'd0),
         row(0, OP_UNUSED_A, 8'd255, BYTES_MAX, 1'b1),
         row(0, OP_UNUSED_B, 8'd0, 48'd0, 1'b0),
         row(1, tpbba_pkg::OP_ACQUIRE, 8'd0, 48'd100, 1'b0),
         row(0, tpbba_pkg::OP_ACQUIRE, 8'd10, 48'd60, 1'b0),
         row(0, tpbba_pkg::OP_ACQUIRE, 8'd11, 48'd50, 1'b1),
         // Low acquire waits behind the high queue even though it would fit.
         row(0, tpbba_pkg::OP_ACQUIRE, 8'd12, 48'd30, 1'b0),
         row(0, tpbba_pkg::OP_TRY, 8'd13, 48'd10, 1'b0),
         row(0, tpbba_pkg::OP_TRY, 8'd14, 48'd40, 1'b1),
         row(0, tpbba_pkg::OP_ACQUIRE, 8'd15, 48'd200, 1'b0),
         // Cancelling the high waiter lets the low head in.
         row(0, tpbba_pkg::OP_CANCEL, 8'd11, 48'd0, 1'b0),
         // Oversized request is admitted once nothing is in flight.
         row(0, tpbba_pkg::OP_RELEASE, 8'd10, 48'd90, 1'b0),
         row(1, tpbba_pkg::OP_ACQUIRE, 8'd0, BYTES_MAX, 1'b0),
         row(0, tpbba_pkg::OP_ACQUIRE, 8'd16, 48'd1000, 1'b1),
         row(0, tpbba_pkg::OP_RECHECK, 8'd17, 48'd0, 1'b0),
         row(0, tpbba_pkg::OP_RELEASE, 8'd255, 48'd1200, 1'b1),
         row(1, tpbba_pkg::OP_ACQUIRE, 8'd0, 48'd0, 1'b0)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) begin
            write_capacity(dir_tab[i].nbytes);
         end else begin
            tw.st = dir_tab[i].st;
            tw.tk = dir_tab[i].tk;
            tw.nbytes = dir_tab[i].ebytes;
            tw.infl = dir_tab[i].einfl;
            tw.last = 1'b1;
            send_request(dir_tab[i].op, dir_tab[i].tk, dir_tab[i].nbytes, dir_tab[i].hi,
                         dir_tab[i].typed, tw);
         end
      end

      // Random part in chunks, each under its own capacity. The idling mode
      // moves on every four chunks: none, sender gaps, receiver stalls, both.
      for (int c = 0; c < CHUNKS; c++) begin
         req_tvalid <= 1'b0;
         case (c / 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         sel = $urandom_range(99);
         if (sel < 10) cap = '0;
         else if (sel < 18) cap = BYTES_MAX;
         else if (sel < 25) cap = 48'({$urandom, $urandom});
         else cap = 48'($urandom_range(1, 120));
         write_capacity(cap);
         for (int k = 0; k < CHUNK_ITEMS; k++) begin
            sel = $urandom_range(99);
            if (k == 0 || sel < 6) op = tpbba_pkg::OP_RECHECK;
            else if (sel < 42) op = tpbba_pkg::OP_ACQUIRE;
            else if (sel < 55) op = tpbba_pkg::OP_TRY;
            else if (sel < 80) op = tpbba_pkg::OP_RELEASE;
            else if (sel < 96) op = tpbba_pkg::OP_CANCEL;
            else op = 3'($urandom_range(OP_UNUSED_A, OP_UNUSED_B));
            // A small ticket pool makes cancels hit waiters, duplicates too.
            tk = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 15))
                                           : 8'($urandom_range(0, 255));
            send_request(op, tk, pick_bytes(op == tpbba_pkg::OP_RELEASE),
                         1'($urandom_range(0, 1)), 1'b0, tw);
            // Unused codes give nothing, so they do not count as items.
            if (op >= OP_UNUSED_A) k--;
         end
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_words.size() > 0 && waited < CYCLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (pending_words.size() > 0) begin
         $display("%0t: %0d expected words never came, next status %0d", $time,
                  pending_words.size(), pending_words[0].st);
         errors++;
      end
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/tpbba_pkg.sv
hdl/tpbba_ctrl.sv
hdl/tpbba_dp.sv
hdl/two_priority_byte_budget_admitter_top.sv
verif/two_priority_byte_budget_admitter_top_tb.sv
